// ===== sv/ted_pkg.sv =====
// Package for the text encoding detector.
// Holds the encoding codes, confidence levels and byte constants.
// No dependencies.
`default_nettype none

package ted_pkg;

  typedef enum logic [2:0] {
    ENC_UTF8    = 3'd0,
    ENC_UTF16LE = 3'd1,
    ENC_UTF16BE = 3'd2,
    ENC_GBK     = 3'd3,
    ENC_LATIN1  = 3'd4,
    ENC_ASCII   = 3'd5
  } enc_t;

  localparam logic [6:0] CONF_FULL   = 7'd100;
  localparam logic [6:0] CONF_UTF8   = 7'd90;
  localparam logic [6:0] CONF_GBK    = 7'd85;
  localparam logic [6:0] CONF_LATIN1 = 7'd20;

  localparam logic [7:0] BOM_UTF8_0 = 8'hEF;
  localparam logic [7:0] BOM_UTF8_1 = 8'hBB;
  localparam logic [7:0] BOM_UTF8_2 = 8'hBF;
  localparam logic [7:0] BOM_FF     = 8'hFF;
  localparam logic [7:0] BOM_FE     = 8'hFE;

  localparam logic [7:0] GBK_LEAD_LO  = 8'h81;
  localparam logic [7:0] GBK_LEAD_HI  = 8'hFE;
  localparam logic [7:0] GBK_TRAIL_LO = 8'h40;
  localparam logic [7:0] GBK_TRAIL_MID_HI = 8'h7E;
  localparam logic [7:0] GBK_TRAIL_MID_LO = 8'h80;

endpackage

`default_nettype wire

// ===== sv/text_encoding_detector_top.sv =====
// Text encoding detector top level: BOM check, ASCII/UTF-8 mask scan, GBK pairing.
// Depends on ted_pkg.
// Verdict is registered on the clock edge that accepts the final (or empty) byte request.
// Throughput: one byte request per cycle; the per-byte state update and verdict
// logic sit between the scan registers and the result register.
// Input is stalled only while a verdict waits and out_ready is low.
// Reset (rst, synchronous): scan state cleared, no verdict pending.
`default_nettype none

module text_encoding_detector_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic [7:0]         data_byte,
  input  wire logic               last_byte,
  input  wire logic               empty_buffer,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      ted_pkg::enc_t      encoding,
  output      logic [6:0]         confidence,
  output      logic               has_bom
);
  import ted_pkg::*;

  logic [23:0] head_bytes, head_bytes_next;
  logic [1:0]  byte_index, byte_index_next;
  logic        all_ascii, all_ascii_next;
  logic        utf8_ok, utf8_ok_next;
  logic [1:0]  continuation_left, continuation_left_next;
  logic        gbk_lead_pending, gbk_lead_pending_next;
  logic        gbk_pair_seen, gbk_pair_seen_next;

  enc_t        enc_sel;
  logic [6:0]  conf_sel;
  logic        bom_sel;
  logic        accept;
  logic        finish;
  logic        is_lead, is_trail;
  logic [7:0]  b0, b1, b2;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign finish   = empty_buffer || last_byte;

  assign is_lead  = (data_byte >= GBK_LEAD_LO) && (data_byte <= GBK_LEAD_HI);
  assign is_trail = ((data_byte >= GBK_TRAIL_LO) && (data_byte <= GBK_TRAIL_MID_HI)) ||
                    ((data_byte >= GBK_TRAIL_MID_LO) && (data_byte <= GBK_LEAD_HI));

  always_comb begin
    head_bytes_next = head_bytes;
    case (byte_index)
      2'd0: head_bytes_next = {head_bytes[23:8], data_byte};
      2'd1: head_bytes_next = {head_bytes[23:16], data_byte, head_bytes[7:0]};
      2'd2: head_bytes_next = {data_byte, head_bytes[15:0]};
      default: head_bytes_next = head_bytes;
    endcase
    byte_index_next = (byte_index == 2'd3) ? byte_index : byte_index + 2'd1;
    all_ascii_next  = all_ascii && !data_byte[7];

    utf8_ok_next           = utf8_ok;
    continuation_left_next = continuation_left;
    if (continuation_left != 2'd0) begin
      if (data_byte[7:6] == 2'b10) begin
        continuation_left_next = continuation_left - 2'd1;
      end else begin
        utf8_ok_next           = 1'b0;
        continuation_left_next = 2'd0;
      end
    end else if (!data_byte[7]) begin
      continuation_left_next = 2'd0;
    end else if (data_byte[7:5] == 3'b110) begin
      continuation_left_next = 2'd1;
    end else if (data_byte[7:4] == 4'b1110) begin
      continuation_left_next = 2'd2;
    end else if (data_byte[7:3] == 5'b11110) begin
      continuation_left_next = 2'd3;
    end else begin
      utf8_ok_next = 1'b0;
    end

    gbk_pair_seen_next = gbk_pair_seen;
    if (gbk_lead_pending && is_trail) begin
      gbk_pair_seen_next    = 1'b1;
      gbk_lead_pending_next = 1'b0;
    end else begin
      gbk_lead_pending_next = is_lead;
    end
  end

  assign b0 = head_bytes_next[7:0];
  assign b1 = head_bytes_next[15:8];
  assign b2 = head_bytes_next[23:16];

  always_comb begin
    enc_sel  = ENC_LATIN1;
    conf_sel = CONF_LATIN1;
    bom_sel  = 1'b0;
    if (empty_buffer) begin
      enc_sel  = ENC_UTF8;
      conf_sel = CONF_FULL;
    end else if (byte_index_next == 2'd3 && b0 == BOM_UTF8_0 &&
                 b1 == BOM_UTF8_1 && b2 == BOM_UTF8_2) begin
      enc_sel  = ENC_UTF8;
      conf_sel = CONF_FULL;
      bom_sel  = 1'b1;
    end else if (byte_index_next >= 2'd2 && b0 == BOM_FF && b1 == BOM_FE) begin
      enc_sel  = ENC_UTF16LE;
      conf_sel = CONF_FULL;
      bom_sel  = 1'b1;
    end else if (byte_index_next >= 2'd2 && b0 == BOM_FE && b1 == BOM_FF) begin
      enc_sel  = ENC_UTF16BE;
      conf_sel = CONF_FULL;
      bom_sel  = 1'b1;
    end else if (all_ascii_next) begin
      enc_sel  = ENC_ASCII;
      conf_sel = CONF_FULL;
    end else if (utf8_ok_next && continuation_left_next == 2'd0) begin
      enc_sel  = ENC_UTF8;
      conf_sel = CONF_UTF8;
    end else if (gbk_pair_seen_next) begin
      enc_sel  = ENC_GBK;
      conf_sel = CONF_GBK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_bytes        <= '0;
      byte_index        <= '0;
      all_ascii         <= 1'b1;
      utf8_ok           <= 1'b1;
      continuation_left <= '0;
      gbk_lead_pending  <= 1'b0;
      gbk_pair_seen     <= 1'b0;
    end else if (accept) begin
      if (finish) begin
        head_bytes        <= '0;
        byte_index        <= '0;
        all_ascii         <= 1'b1;
        utf8_ok           <= 1'b1;
        continuation_left <= '0;
        gbk_lead_pending  <= 1'b0;
        gbk_pair_seen     <= 1'b0;
      end else begin
        head_bytes        <= head_bytes_next;
        byte_index        <= byte_index_next;
        all_ascii         <= all_ascii_next;
        utf8_ok           <= utf8_ok_next;
        continuation_left <= continuation_left_next;
        gbk_lead_pending  <= gbk_lead_pending_next;
        gbk_pair_seen     <= gbk_pair_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && finish) begin
      encoding   <= enc_sel;
      confidence <= conf_sel;
      has_bom    <= bom_sel;
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench for text_encoding_detector_top: directed byte buffers, then random
// buffers checked against an in-bench classifier. Depends on ted_pkg and the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ted_pkg::*;

  typedef struct packed {
    enc_t       enc;
    logic [6:0] conf;
    logic       bom;
  } verdict_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       empty;
    logic       fixed;
    verdict_t   want;
  } stim_row_t;

  localparam verdict_t NO_VERDICT = '{ENC_UTF8, 7'd0, 1'b0};

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       empty_buffer = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  enc_t       encoding;
  logic [6:0] confidence;
  logic       has_bom;

  text_encoding_detector_top uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .empty_buffer (empty_buffer),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .encoding     (encoding),
    .confidence   (confidence),
    .has_bom      (has_bom)
  );

  always #6 clk = ~clk;

  // request takes, sampled mid-cycle when everything is settled
  bit in_take = 1'b0;
  bit out_take = 1'b0;
  always @(negedge clk) begin
    in_take  = (in_valid && in_ready) === 1'b1;
    out_take = (out_valid && out_ready) === 1'b1;
  end

  // classifier state
  logic [7:0] head [3];
  logic [1:0] seen_cnt;
  logic       only_ascii;
  logic       utf8_clean;
  logic [1:0] cont_owed;
  logic       gbk_lead_open;
  logic       gbk_pair_found;

  verdict_t   verdicts [$];
  logic [7:0] text_q [$];
  int         errors = 0;
  int         sent_cnt = 0;
  int         burst_left = 0;
  logic       hold_rx = 1'b0;

  stim_row_t dir_rows [24] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, '{ENC_UTF8,    CONF_FULL,   1'b0}},
    '{8'hEF, 1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{8'hBB, 1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{8'hBF, 1'b1, 1'b0, 1'b1, '{ENC_UTF8,    CONF_FULL,   1'b1}},
    '{8'hFF, 1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{8'hFE, 1'b1, 1'b0, 1'b1, '{ENC_UTF16LE, CONF_FULL,   1'b1}},
    '{8'hFE, 1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{8'hFF, 1'b1, 1'b0, 1'b1, '{ENC_UTF16BE, CONF_FULL,   1'b1}},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{8'h7F, 1'b1, 1'b0, 1'b1, '{ENC_ASCII,   CONF_FULL,   1'b0}},
    '{8'hFF, 1'b1, 1'b0, 1'b1, '{ENC_LATIN1,  CONF_LATIN1, 1'b0}},
    '{8'hC0, 1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{8'h80, 1'b1, 1'b0, 1'b1, '{ENC_UTF8,    CONF_UTF8,   1'b0}},
    '{8'hE4, 1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{8'hB8, 1'b1, 1'b0, 1'b0, NO_VERDICT},
    '{8'h41, 1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{8'hC3, 1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{8'h5A, 1'b1, 1'b1, 1'b1, '{ENC_UTF8,    CONF_FULL,   1'b0}},
    '{8'hC3, 1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{8'h28, 1'b1, 1'b0, 1'b0, NO_VERDICT},
    '{8'hEF, 1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{8'hBB, 1'b1, 1'b0, 1'b0, NO_VERDICT},
    '{8'h81, 1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{8'h7E, 1'b1, 1'b0, 1'b1, '{ENC_GBK,     CONF_GBK,    1'b0}}
  };

  function automatic void scan_clear();
    head           = '{8'h00, 8'h00, 8'h00};
    seen_cnt       = 2'd0;
    only_ascii     = 1'b1;
    utf8_clean     = 1'b1;
    cont_owed      = 2'd0;
    gbk_lead_open  = 1'b0;
    gbk_pair_found = 1'b0;
  endfunction

  task automatic classify_byte(input logic [7:0] b, input logic lst, input logic emp,
                               output bit made, output verdict_t v);
    bit is_trail;
    is_trail = (b >= GBK_TRAIL_LO && b <= GBK_TRAIL_MID_HI) ||
               (b >= GBK_TRAIL_MID_LO && b <= GBK_LEAD_HI);
    made = 1'b0;
    v = NO_VERDICT;
    if (emp) begin
      made = 1'b1;
      v = '{ENC_UTF8, CONF_FULL, 1'b0};
      scan_clear();
    end else begin
      if (seen_cnt < 2'd3) begin
        head[seen_cnt] = b;
        seen_cnt++;
      end
      if (b > 8'h7F) only_ascii = 1'b0;
      if (cont_owed != 2'd0) begin
        if ((b & 8'hC0) == 8'h80) cont_owed--;
        else begin
          utf8_clean = 1'b0;
          cont_owed = 2'd0;
        end
      end else if (b <= 8'h7F) begin
      end else if ((b & 8'hE0) == 8'hC0) cont_owed = 2'd1;
      else if ((b & 8'hF0) == 8'hE0) cont_owed = 2'd2;
      else if ((b & 8'hF8) == 8'hF0) cont_owed = 2'd3;
      else utf8_clean = 1'b0;
      if (gbk_lead_open && is_trail) begin
        gbk_pair_found = 1'b1;
        gbk_lead_open = 1'b0;
      end else begin
        gbk_lead_open = (b >= GBK_LEAD_LO && b <= GBK_LEAD_HI);
      end
      if (lst) begin
        made = 1'b1;
        if (seen_cnt == 2'd3 && head[0] == BOM_UTF8_0 && head[1] == BOM_UTF8_1 &&
            head[2] == BOM_UTF8_2)
          v = '{ENC_UTF8, CONF_FULL, 1'b1};
        else if (seen_cnt >= 2'd2 && head[0] == BOM_FF && head[1] == BOM_FE)
          v = '{ENC_UTF16LE, CONF_FULL, 1'b1};
        else if (seen_cnt >= 2'd2 && head[0] == BOM_FE && head[1] == BOM_FF)
          v = '{ENC_UTF16BE, CONF_FULL, 1'b1};
        else if (only_ascii)
          v = '{ENC_ASCII, CONF_FULL, 1'b0};
        else if (utf8_clean && cont_owed == 2'd0)
          v = '{ENC_UTF8, CONF_UTF8, 1'b0};
        else if (gbk_pair_found)
          v = '{ENC_GBK, CONF_GBK, 1'b0};
        else
          v = '{ENC_LATIN1, CONF_LATIN1, 1'b0};
        scan_clear();
      end
    end
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // one byte request, with burst/gap idling in front of it
  task automatic put_byte(input logic [7:0] b, input logic lst, input logic emp,
                          input bit typed, input verdict_t typed_v);
    bit       made;
    verdict_t v;
    int       gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    data_byte    <= b;
    last_byte    <= lst;
    empty_buffer <= emp;
    do @(posedge clk); while (!in_take);
    burst_left--;
    sent_cnt++;
    classify_byte(b, lst, emp, made, v);
    if (typed) v = typed_v;
    if (made) verdicts.push_back(v);
  endtask

  task automatic send_text(input bit cut_short);
    int i;
    if (text_q.size() == 0) begin
      put_byte(8'($urandom), 1'($urandom), 1'b1, 1'b0, NO_VERDICT);
    end else begin
      for (i = 0; i < text_q.size(); i++)
        put_byte(text_q[i], (i == text_q.size() - 1) && !cut_short, 1'b0, 1'b0, NO_VERDICT);
      if (cut_short) put_byte(8'($urandom), 1'($urandom), 1'b1, 1'b0, NO_VERDICT);
    end
    text_q.delete();
  endtask

  task automatic add_utf8_char();
    int n;
    n = $urandom_range(0, 3);
    case (n)
      0: text_q.push_back(8'($urandom_range(0, 127)));
      1: text_q.push_back(8'hC0 | 8'($urandom_range(0, 31)));
      2: text_q.push_back(8'hE0 | 8'($urandom_range(0, 15)));
      default: text_q.push_back(8'hF0 | 8'($urandom_range(0, 7)));
    endcase
    repeat (n) text_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
  endtask

  task automatic add_gbk_pair();
    text_q.push_back(8'($urandom_range(8'h81, 8'hFE)));
    if ($urandom_range(0, 1)) text_q.push_back(8'($urandom_range(8'h40, 8'h7E)));
    else text_q.push_back(8'($urandom_range(8'h80, 8'hFE)));
  endtask

  // receiver: ready pattern changes mode when the current mode's run expires
  initial begin
    int mode;
    int mode_cnt;
    mode = 0;
    mode_cnt = 0;
    forever begin
      @(posedge clk);
      if (mode_cnt == 0) begin
        mode = $urandom_range(0, 3);
        mode_cnt = $urandom_range(16, 96);
      end
      mode_cnt--;
      if (hold_rx) out_ready <= 1'b0;
      else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom);
          2: out_ready <= (mode_cnt % 3 == 0);
          default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // long receiver hold-off while bytes keep coming
  initial begin
    wait (sent_cnt >= 300);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (400) @(posedge clk);
    hold_rx <= 1'b0;
  end

  always @(posedge clk) begin : check_results
    verdict_t want;
    if (out_take) begin
      if (verdicts.size() == 0) begin
        flag_mismatch("verdict with none pending, encoding", encoding, -1);
      end else begin
        want = verdicts.pop_front();
        if (encoding !== want.enc) flag_mismatch("encoding", encoding, want.enc);
        if (confidence !== want.conf) flag_mismatch("confidence", confidence, want.conf);
        if (has_bom !== want.bom) flag_mismatch("has_bom", has_bom, want.bom);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int  i;
    int  n;
    bit  drained;
    drained = 1'b0;
    scan_clear();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < 24; i++)
      put_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].empty,
               dir_rows[i].fixed, dir_rows[i].want);

    while (sent_cnt < 1424) begin
      n = $urandom_range(1, 10);
      case ($urandom_range(0, 11))
        0: repeat (n) text_q.push_back(8'($urandom_range(0, 127)));
        1, 2: repeat (n / 2 + 1) add_utf8_char();
        3, 4: repeat (n / 2 + 1) begin
          add_gbk_pair();
          if ($urandom_range(0, 1)) text_q.push_back(8'($urandom_range(0, 127)));
        end
        5: begin
          case ($urandom_range(0, 2))
            0: begin
              text_q.push_back(BOM_UTF8_0);
              text_q.push_back(BOM_UTF8_1);
              text_q.push_back(BOM_UTF8_2);
            end
            1: begin
              text_q.push_back(BOM_FF);
              text_q.push_back(BOM_FE);
            end
            default: begin
              text_q.push_back(BOM_FE);
              text_q.push_back(BOM_FF);
            end
          endcase
          repeat ($urandom_range(0, 4)) text_q.push_back(8'($urandom));
        end
        6: begin
          // valid text, then a cut-off or broken sequence
          repeat (n / 3 + 1) add_utf8_char();
          text_q.push_back(8'hC0 | 8'($urandom_range(0, 63)));
          if ($urandom_range(0, 1)) text_q.push_back(8'($urandom));
        end
        7, 8: repeat (n) text_q.push_back(8'($urandom));
        9: repeat ($urandom_range(1, 2)) begin
          case ($urandom_range(0, 3))
            0: text_q.push_back(BOM_UTF8_0);
            1: text_q.push_back(BOM_FF);
            2: text_q.push_back(BOM_FE);
            default: text_q.push_back(8'($urandom));
          endcase
        end
        10: ;
        default: repeat ($urandom_range(20, 60)) begin
          if ($urandom_range(0, 7) == 0) text_q.push_back(8'($urandom));
          else add_utf8_char();
        end
      endcase
      send_text($urandom_range(0, 15) == 0);

      if (!drained && sent_cnt >= 900) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (verdicts.size() != 0);
      end
    end

    in_valid <= 1'b0;
    while (verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0 && verdicts.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
